@@ rtl/pwf_pkg.sv @@
package pwf_pkg;

  localparam int ORDER    = 10;
  localparam int REQ_W    = 2;
  localparam int SAMPLE_W = 16;
  localparam int IDX_W    = 4;
  localparam int COEF_W   = 16;
  localparam int FRAC_W   = 12;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  // x*2^12 plus 2*ORDER products of 31 significant bits, with sign
  localparam int ACC_W    = PROD_W + $clog2(2 * ORDER + 1);
  // wide enough for both the index field and tap numbers up to ORDER
  localparam int TAP_W    = ($clog2(ORDER + 1) > IDX_W) ? $clog2(ORDER + 1) : IDX_W;

  localparam logic signed [ACC_W-1:0] SAT_MAX  = ACC_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_MIN  = -ACC_W'(1 << (SAMPLE_W - 1));
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (FRAC_W - 1));

  typedef enum logic [REQ_W-1:0] {
    REQ_FILTER    = 2'd0,
    REQ_LOAD_ZERO = 2'd1,
    REQ_LOAD_POLE = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WRITE
  } state_e;

  // partial sum travelling down the cell row
  typedef struct packed {
    logic                    tok;
    logic signed [ACC_W-1:0] acc;
  } link_t;

  typedef struct packed {
    logic load_z;
    logic load_p;
    logic shift;
  } cell_ctl_t;

endpackage

@@ rtl/pwf_in_if.sv @@
interface pwf_in_if;
  logic                                   valid;
  logic                                   ready;
  logic        [pwf_pkg::REQ_W-1:0]       req_type;
  logic signed [pwf_pkg::SAMPLE_W-1:0]    sample_in;
  logic        [pwf_pkg::IDX_W-1:0]       coef_index;
  logic signed [pwf_pkg::COEF_W-1:0]      coef_value;

  modport source (output valid, req_type, sample_in, coef_index, coef_value, input ready);
  modport sink   (input valid, req_type, sample_in, coef_index, coef_value, output ready);
endinterface

@@ rtl/pwf_out_if.sv @@
interface pwf_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pwf_pkg::SAMPLE_W-1:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink   (input valid, sample_out, output ready);
endinterface

@@ rtl/perceptual_weighting_filter_core.sv @@
// Perceptual weighting filter, direct-form pole-zero of order ORDER, one sample
// per transfer: y = x + sum z[k]*x[n-k] - sum p[k]*y[n-k], rounded half up from
// Q24.12, saturated to 16 bits, and the saturated value fed back. A row of ORDER
// cells each holds one tap (past input, past output, zero and pole coefficient);
// the partial sum enters the first cell as x*4096 and picks up one tap's term per
// cycle as it moves down the row. A filter transfer passes the sum down the cell
// row, rounds and saturates it into the result register, then writes the output
// register and shifts both histories one cell along; the input is not ready
// again until then, or longer if the previous result has not been taken.
// Coefficient loads (zero or pole, taps 1..ORDER) give no result; loads to tap 0
// or above ORDER and the unused request code are dropped. A finished result waits
// in the output register while the next transfer is taken in. All history and
// coefficients reset to zero.
module perceptual_weighting_filter_core (
  input logic       clk_i,
  input logic       rst_ni,
  pwf_in_if.sink    in_i,
  pwf_out_if.source out_o
);

  pwf_pkg::state_e state_q, state_d;

  pwf_pkg::link_t     link [pwf_pkg::ORDER+1];
  pwf_pkg::cell_ctl_t ctl  [pwf_pkg::ORDER];
  logic signed [pwf_pkg::SAMPLE_W-1:0] xh [pwf_pkg::ORDER];
  logic signed [pwf_pkg::SAMPLE_W-1:0] yh [pwf_pkg::ORDER];

  logic signed [pwf_pkg::SAMPLE_W-1:0] x_q;       // sample in flight
  logic signed [pwf_pkg::SAMPLE_W-1:0] y_q, y_d;  // rounded, saturated result
  logic signed [pwf_pkg::SAMPLE_W-1:0] out_q;
  logic                                out_vld_q;

  logic signed [pwf_pkg::ACC_W-1:0] rnd, shifted;

  logic in_take, start, done, out_free, commit;

  // handshake / control outputs
  always_comb begin
    in_i.ready = (state_q == pwf_pkg::ST_IDLE);
    out_free   = !out_vld_q || out_o.ready;
    commit     = (state_q == pwf_pkg::ST_WRITE) && out_free;
    done       = (state_q == pwf_pkg::ST_RUN) && link[pwf_pkg::ORDER].tok;
  end

  assign in_take = in_i.valid && in_i.ready;
  assign start   = in_take && (in_i.req_type == pwf_pkg::REQ_FILTER);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pwf_pkg::ST_IDLE:  if (start)  state_d = pwf_pkg::ST_RUN;
      pwf_pkg::ST_RUN:   if (done)   state_d = pwf_pkg::ST_WRITE;
      pwf_pkg::ST_WRITE: if (commit) state_d = pwf_pkg::ST_IDLE;
      default:                       state_d = pwf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= pwf_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  // seed of the sum: x in units of 2^-12
  always_comb begin
    link[0].tok = start;
    link[0].acc = pwf_pkg::ACC_W'(in_i.sample_in) <<< pwf_pkg::FRAC_W;
  end

  // cell row
  for (genvar k = 0; k < pwf_pkg::ORDER; k++) begin : g_cell
    logic tap_hit;
    assign tap_hit = pwf_pkg::TAP_W'(in_i.coef_index) == pwf_pkg::TAP_W'(k + 1);

    always_comb begin
      ctl[k].load_z = in_take && tap_hit && (in_i.req_type == pwf_pkg::REQ_LOAD_ZERO);
      ctl[k].load_p = in_take && tap_hit && (in_i.req_type == pwf_pkg::REQ_LOAD_POLE);
      ctl[k].shift  = commit;
    end

    if (k == 0) begin : g_head
      pwf_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctl_i  (ctl[k]),
        .coef_i (in_i.coef_value),
        .x_i    (x_q),
        .y_i    (y_q),
        .x_o    (xh[k]),
        .y_o    (yh[k]),
        .link_i (link[k]),
        .link_o (link[k+1])
      );
    end else begin : g_body
      pwf_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctl_i  (ctl[k]),
        .coef_i (in_i.coef_value),
        .x_i    (xh[k-1]),
        .y_i    (yh[k-1]),
        .x_o    (xh[k]),
        .y_o    (yh[k]),
        .link_i (link[k]),
        .link_o (link[k+1])
      );
    end
  end

  // round half up, then clamp to the sample range
  always_comb begin
    rnd     = link[pwf_pkg::ORDER].acc + pwf_pkg::ROUND_HALF;
    shifted = rnd >>> pwf_pkg::FRAC_W;
    if (shifted > pwf_pkg::SAT_MAX)      y_d = pwf_pkg::SAMPLE_W'(pwf_pkg::SAT_MAX);
    else if (shifted < pwf_pkg::SAT_MIN) y_d = pwf_pkg::SAMPLE_W'(pwf_pkg::SAT_MIN);
    else                                 y_d = pwf_pkg::SAMPLE_W'(shifted);
  end

  always_ff @(posedge clk_i) begin
    if (start)  x_q   <= in_i.sample_in;
    if (done)   y_q   <= y_d;
    if (commit) out_q <= y_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)                    out_vld_q <= 1'b0;
    else if (commit)                out_vld_q <= 1'b1;
    else if (out_o.ready)           out_vld_q <= 1'b0;
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.sample_out = out_q;

  // last cell's history outputs fall off the end of the shift line
  logic unused_tail;
  assign unused_tail = ^{xh[pwf_pkg::ORDER-1], yh[pwf_pkg::ORDER-1]};

endmodule

@@ rtl/pwf_cell.sv @@
// One tap: holds x[n-k], y[n-k], z[k], p[k]; adds its term to the passing sum.
module pwf_cell (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pwf_pkg::cell_ctl_t                   ctl_i,
  input  logic signed [pwf_pkg::COEF_W-1:0]    coef_i,
  input  logic signed [pwf_pkg::SAMPLE_W-1:0]  x_i,
  input  logic signed [pwf_pkg::SAMPLE_W-1:0]  y_i,
  output logic signed [pwf_pkg::SAMPLE_W-1:0]  x_o,
  output logic signed [pwf_pkg::SAMPLE_W-1:0]  y_o,
  input  pwf_pkg::link_t                       link_i,
  output pwf_pkg::link_t                       link_o
);

  logic signed [pwf_pkg::SAMPLE_W-1:0] xh_q, yh_q;
  logic signed [pwf_pkg::COEF_W-1:0]   z_q, p_q;
  logic signed [pwf_pkg::PROD_W-1:0]   prod_z, prod_p;
  pwf_pkg::link_t                      link_d;
  logic                                tok_q;
  logic signed [pwf_pkg::ACC_W-1:0]    acc_q;

  assign prod_z = z_q * xh_q;
  assign prod_p = p_q * yh_q;

  always_comb begin
    link_d.tok = link_i.tok;
    link_d.acc = link_i.acc + pwf_pkg::ACC_W'(prod_z) - pwf_pkg::ACC_W'(prod_p);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xh_q  <= '0;
      yh_q  <= '0;
      z_q   <= '0;
      p_q   <= '0;
      tok_q <= 1'b0;
    end else begin
      tok_q <= link_d.tok;
      if (ctl_i.shift) begin
        xh_q <= x_i;
        yh_q <= y_i;
      end
      if (ctl_i.load_z) z_q <= coef_i;
      if (ctl_i.load_p) p_q <= coef_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_d.tok) acc_q <= link_d.acc;
  end

  always_comb begin
    link_o.tok = tok_q;
    link_o.acc = acc_q;
  end

  assign x_o = xh_q;
  assign y_o = yh_q;

endmodule
